// File: rtl/hsbl_pkg.sv
// Shared types and constants for the handshake serial byte link.
// No dependencies; used by handshake_serial_byte_link.
`default_nettype none

package hsbl_pkg;

  // Link sequencer modes
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_START = 2'd1,
    MODE_SEND  = 2'd2,
    MODE_RECV  = 2'd3
  } link_mode_t;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t STATUS_NONE     = 3'd0;
  localparam status_t STATUS_SENT     = 3'd1;
  localparam status_t STATUS_TIMEOUT  = 3'd2;
  localparam status_t STATUS_RECEIVED = 3'd3;
  localparam status_t STATUS_RX_ERROR = 3'd4;

  // Request kinds carried on s_tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // Register map
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_ACK_WAIT_LIMIT     = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_RECEIVE_TICK_LIMIT = 3'd4;

  localparam logic [7:0]  ACK_WAIT_LIMIT_RESET     = 8'd100;
  localparam logic [15:0] RECEIVE_TICK_LIMIT_RESET = 16'd100;

  // One result item
  typedef struct packed {
    logic       busy_res;
    logic [7:0] rx_value;
    logic       strobe_out;
    logic       data_out;
    status_t    status;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/handshake_serial_byte_link.sv
// Handshake serial byte link: top level, state machine and result buffering.
// Depends on hsbl_pkg.
//
// Usage: every request on the s_* channel is one poll tick of the wire
// sampler. s_tuser is the op (1 asks to send s_tdata[7:0] when idle), and
// s_tdata also carries the sampled partner data/ack level and strobe level.
// Each accepted request yields exactly one result on the m_* channel: the
// wire levels to drive after the tick, the received byte, the busy flag,
// and a status code on m_tuser (none, sent, send timeout, received, error).
// Throughput is one request per cycle while s_tready is high; the sequencer state
// register is loaded at the accepting edge, and so is the output register when it
// is free, so the result is then offered on m_* in the cycle right after that edge.
// A two-entry output (output register plus skid register) keeps s_tready
// high while one result waits; s_tready drops only once the skid entry is
// also occupied by a stalled receiver, and rises again in the cycle after the
// receiver takes a result. No result is dropped or repeated.
// Reset (rst, synchronous) returns the link to idle with both wires low and
// loads the reset limits of 100 ticks. The user must write the APB limits (0x0
// ack_wait_limit, 0x4 receive_tick_limit) only while idle (not enforced).
`default_nettype none

module handshake_serial_byte_link #(
  parameter int unsigned DATA_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // [7:0] tx_value, [8] data_in, [9] strobe_in
  input  wire logic        s_tuser,  // [0] op
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // [0] data_out, [1] strobe_out, [9:2] rx_value,
                                     // [10] busy_res
  output logic [2:0]       m_tuser,  // [2:0] status
  // configuration
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [hsbl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned SW   = DATA_BITS + 1;         // data bits plus stop bit
  localparam int unsigned CW   = $clog2(DATA_BITS + 2); // holds DATA_BITS+1
  localparam int unsigned TXW  = (DATA_BITS < 8) ? DATA_BITS : 8;
  localparam logic [CW-1:0] LAST_COUNT = CW'(DATA_BITS + 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [7:0]  ack_wait_limit;
  logic [15:0] receive_tick_limit;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait_limit     <= hsbl_pkg::ACK_WAIT_LIMIT_RESET;
      receive_tick_limit <= hsbl_pkg::RECEIVE_TICK_LIMIT_RESET;
    end else if (cfg_write) begin
      if (paddr == hsbl_pkg::ADDR_ACK_WAIT_LIMIT) begin
        ack_wait_limit <= pwdata[7:0];
      end
      if (paddr == hsbl_pkg::ADDR_RECEIVE_TICK_LIMIT) begin
        receive_tick_limit <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    unique case (paddr)
      hsbl_pkg::ADDR_ACK_WAIT_LIMIT:     prdata = {24'd0, ack_wait_limit};
      hsbl_pkg::ADDR_RECEIVE_TICK_LIMIT: prdata = {16'd0, receive_tick_limit};
      default:                           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Request fields
  // ---------------------------------------------------------------------
  logic       op;
  logic [7:0] tx_value;
  logic       data_in;
  logic       strobe_in;
  logic       accept;

  assign op        = s_tuser;
  assign tx_value  = s_tdata[7:0];
  assign data_in   = s_tdata[8];
  assign strobe_in = s_tdata[9];
  assign accept    = s_tvalid && s_tready;

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  hsbl_pkg::link_mode_t link_mode, link_mode_next;
  logic [SW-1:0]  bit_shift, bit_shift_next;
  logic [CW-1:0]  bit_count, bit_count_next;
  logic           expected_ack, expected_ack_next;
  logic [15:0]    wait_count, wait_count_next;
  logic           strobe_was_high, strobe_was_high_next;
  logic           data_level, data_level_next;
  logic           strobe_level, strobe_level_next;

  hsbl_pkg::result_t result;

  logic [SW-1:0]  shift_load;
  logic [SW-1:0]  shift_sel;
  logic [16:0]    wait_inc;
  logic [CW-1:0]  count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode       <= hsbl_pkg::MODE_IDLE;
      bit_shift       <= '0;
      bit_count       <= '0;
      expected_ack    <= 1'b1;
      wait_count      <= '0;
      strobe_was_high <= 1'b1;
      data_level      <= 1'b0;
      strobe_level    <= 1'b0;
    end else if (accept) begin
      link_mode       <= link_mode_next;
      bit_shift       <= bit_shift_next;
      bit_count       <= bit_count_next;
      expected_ack    <= expected_ack_next;
      wait_count      <= wait_count_next;
      strobe_was_high <= strobe_was_high_next;
      data_level      <= data_level_next;
      strobe_level    <= strobe_level_next;
    end
  end

  always_comb begin
    shift_load = '0;
    shift_load[TXW-1:0] = tx_value[TXW-1:0];
    shift_load[DATA_BITS] = 1'b1;
    shift_sel = bit_shift >> bit_count;
    wait_inc  = {1'b0, wait_count} + 17'd1;
    count_inc = bit_count + CW'(1);

    link_mode_next       = link_mode;
    bit_shift_next       = bit_shift;
    bit_count_next       = bit_count;
    expected_ack_next    = expected_ack;
    wait_count_next      = wait_count;
    strobe_was_high_next = strobe_was_high;
    data_level_next      = data_level;
    strobe_level_next    = strobe_level;
    result.status        = hsbl_pkg::STATUS_NONE;
    result.rx_value      = 8'd0;

    unique case (link_mode)
      hsbl_pkg::MODE_IDLE: begin
        if (op == hsbl_pkg::OP_SEND) begin
          // raise strobe and wait for the first acknowledge
          bit_shift_next    = shift_load;
          bit_count_next    = '0;
          expected_ack_next = 1'b1;
          wait_count_next   = '0;
          strobe_level_next = 1'b1;
          data_level_next   = 1'b0;
          link_mode_next    = hsbl_pkg::MODE_START;
        end else if (strobe_in) begin
          // partner starts a byte: acknowledge it
          bit_shift_next       = '0;
          bit_count_next       = '0;
          wait_count_next      = '0;
          strobe_was_high_next = 1'b1;
          data_level_next      = 1'b1;
          link_mode_next       = hsbl_pkg::MODE_RECV;
        end
      end
      hsbl_pkg::MODE_START, hsbl_pkg::MODE_SEND: begin
        if (link_mode == hsbl_pkg::MODE_SEND && strobe_level) begin
          // strobe-high gap: present the next bit and drop strobe
          data_level_next   = shift_sel[0];
          strobe_level_next = 1'b0;
          wait_count_next   = '0;
        end else if (data_in == expected_ack) begin
          expected_ack_next = ~expected_ack;
          wait_count_next   = '0;
          if (link_mode == hsbl_pkg::MODE_START) begin
            data_level_next   = bit_shift[0];
            strobe_level_next = 1'b0;
            link_mode_next    = hsbl_pkg::MODE_SEND;
          end else begin
            bit_count_next  = count_inc;
            data_level_next = 1'b0;
            if (count_inc >= LAST_COUNT) begin
              result.status     = hsbl_pkg::STATUS_SENT;
              link_mode_next    = hsbl_pkg::MODE_IDLE;
              strobe_level_next = 1'b0;
            end else begin
              strobe_level_next = 1'b1;
            end
          end
        end else begin
          wait_count_next = wait_inc[15:0];
          if (wait_inc >= 17'(ack_wait_limit)) begin
            result.status     = hsbl_pkg::STATUS_TIMEOUT;
            link_mode_next    = hsbl_pkg::MODE_IDLE;
            data_level_next   = 1'b0;
            strobe_level_next = 1'b0;
          end
        end
      end
      hsbl_pkg::MODE_RECV: begin
        wait_count_next = wait_inc[15:0];
        if (!strobe_in && strobe_was_high) begin
          // falling strobe: sample data and toggle acknowledge
          for (int i = 0; i < SW; i++) begin
            if (data_in && bit_count == CW'(i)) begin
              bit_shift_next[i] = 1'b1;
            end
          end
          bit_count_next       = count_inc;
          strobe_was_high_next = 1'b0;
          data_level_next      = ~data_level;
        end else if (strobe_in) begin
          strobe_was_high_next = 1'b1;
        end
        if (bit_count_next >= LAST_COUNT || wait_inc >= 17'(receive_tick_limit)) begin
          if (bit_count_next >= LAST_COUNT && bit_shift_next[DATA_BITS]) begin
            result.status   = hsbl_pkg::STATUS_RECEIVED;
            result.rx_value = 8'(bit_shift_next[TXW-1:0]);
          end else begin
            result.status = hsbl_pkg::STATUS_RX_ERROR;
          end
          link_mode_next    = hsbl_pkg::MODE_IDLE;
          data_level_next   = 1'b0;
          strobe_level_next = 1'b0;
        end
      end
      default: begin
        link_mode_next = hsbl_pkg::MODE_IDLE;
      end
    endcase

    result.data_out   = data_level_next;
    result.strobe_out = strobe_level_next;
    result.busy_res   = (link_mode_next != hsbl_pkg::MODE_IDLE);
  end

  // ---------------------------------------------------------------------
  // Output register with skid entry
  // ---------------------------------------------------------------------
  hsbl_pkg::result_t out_data, skid_data;
  logic              out_valid, skid_valid;
  logic              out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : result;
    end
    if (!out_free && accept) begin
      skid_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_data.status;
  assign m_tdata  = {5'd0, out_data.busy_res, out_data.rx_value,
                     out_data.strobe_out, out_data.data_out};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  a_idle_wires_low: assert property (@(posedge clk) disable iff (rst)
    (link_mode == hsbl_pkg::MODE_IDLE) |-> (!data_level && !strobe_level))
    else $error("idle link drives a wire high");

  a_end_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != hsbl_pkg::STATUS_NONE) |-> !out_data.busy_res)
    else $error("result reports an end of transfer while still busy");

endmodule

`default_nettype wire

// File: bench/hsbl_link_checker.sv
// Result checker for the handshake serial byte link: snoops the request, result and APB
// channels, predicts every result from its own copy of the link state and compares.
// Depends on hsbl_pkg.

module hsbl_link_checker #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [7:0] tx_value, [8] data_in,
                                                   // [9] strobe_in
  input  logic                          s_tuser,   // [0] op
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [15:0]                   m_tdata,   // [0] data_out, [1] strobe_out,
                                                   // [9:2] rx_value, [10] busy_res
  input  logic [2:0]                    m_tuser,   // [2:0] status
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hsbl_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  input  logic [31:0]                   prdata,
  input  logic                          pready,
  output int                            errors,
  output int                            pending,
  output logic                          link_idle
);

  localparam int unsigned FRAME_W = DATA_BITS + 1;
  localparam logic [FRAME_W-1:0] DATA_MASK = {1'b0, {DATA_BITS{1'b1}}};

  logic [7:0]           ack_limit;
  logic [15:0]          rx_tick_limit;
  hsbl_pkg::link_mode_t mode;
  logic [FRAME_W-1:0]   frame_bits;
  int unsigned          bit_idx;
  int unsigned          wait_ticks;
  logic                 ack_level;
  logic                 strobe_seen;
  logic                 data_lvl;
  logic                 strobe_lvl;
  hsbl_pkg::result_t    link_results_q[$];

  initial errors = 0;

  function automatic void drop_link();
    mode       = hsbl_pkg::MODE_IDLE;
    data_lvl   = 1'b0;
    strobe_lvl = 1'b0;
  endfunction

  // Advance the link by one poll tick and return the levels and status it reports.
  function automatic hsbl_pkg::result_t step_link(logic op, logic [7:0] txv, logic din,
                                                  logic sin);
    hsbl_pkg::result_t r;
    r = '0;
    r.status = hsbl_pkg::STATUS_NONE;
    if (mode == hsbl_pkg::MODE_IDLE) begin
      if (op == hsbl_pkg::OP_SEND) begin
        frame_bits = (FRAME_W'(txv) & DATA_MASK) | (FRAME_W'(1) << DATA_BITS);
        bit_idx    = 0;
        ack_level  = 1'b1;
        wait_ticks = 0;
        strobe_lvl = 1'b1;
        data_lvl   = 1'b0;
        mode       = hsbl_pkg::MODE_START;
      end else if (sin) begin
        frame_bits  = '0;
        bit_idx     = 0;
        wait_ticks  = 0;
        strobe_seen = 1'b1;
        data_lvl    = 1'b1;
        mode        = hsbl_pkg::MODE_RECV;
      end
    end else if (mode == hsbl_pkg::MODE_START ||
                 (mode == hsbl_pkg::MODE_SEND && !strobe_lvl)) begin
      if (din == ack_level) begin
        ack_level  = ~ack_level;
        wait_ticks = 0;
        if (mode == hsbl_pkg::MODE_START) begin
          data_lvl   = frame_bits[0];
          strobe_lvl = 1'b0;
          mode       = hsbl_pkg::MODE_SEND;
        end else begin
          bit_idx++;
          data_lvl = 1'b0;
          if (bit_idx >= FRAME_W) begin
            r.status = hsbl_pkg::STATUS_SENT;
            drop_link();
          end else begin
            strobe_lvl = 1'b1;
          end
        end
      end else begin
        wait_ticks++;
        if (wait_ticks >= ack_limit) begin
          r.status = hsbl_pkg::STATUS_TIMEOUT;
          drop_link();
        end
      end
    end else if (mode == hsbl_pkg::MODE_SEND) begin
      // strobe-high gap: put out the next bit and drop strobe
      data_lvl   = frame_bits[bit_idx];
      strobe_lvl = 1'b0;
      wait_ticks = 0;
    end else begin
      wait_ticks++;
      if (!sin && strobe_seen) begin
        if (din) frame_bits[bit_idx] = 1'b1;
        bit_idx++;
        strobe_seen = 1'b0;
        data_lvl    = ~data_lvl;
      end else if (sin) begin
        strobe_seen = 1'b1;
      end
      if (bit_idx >= FRAME_W || wait_ticks >= rx_tick_limit) begin
        if (bit_idx >= FRAME_W && frame_bits[DATA_BITS]) begin
          r.status   = hsbl_pkg::STATUS_RECEIVED;
          r.rx_value = 8'(frame_bits[DATA_BITS-1:0]);
        end else begin
          r.status = hsbl_pkg::STATUS_RX_ERROR;
        end
        drop_link();
      end
    end
    r.data_out   = data_lvl;
    r.strobe_out = strobe_lvl;
    r.busy_res   = (mode != hsbl_pkg::MODE_IDLE);
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    hsbl_pkg::result_t want;
    if (rst) begin
      ack_limit     = hsbl_pkg::ACK_WAIT_LIMIT_RESET;
      rx_tick_limit = hsbl_pkg::RECEIVE_TICK_LIMIT_RESET;
      mode          = hsbl_pkg::MODE_IDLE;
      frame_bits    = '0;
      bit_idx       = 0;
      ack_level     = 1'b1;
      wait_ticks    = 0;
      strobe_seen   = 1'b1;
      data_lvl      = 1'b0;
      strobe_lvl    = 1'b0;
      link_results_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == hsbl_pkg::ADDR_ACK_WAIT_LIMIT) ack_limit = pwdata[7:0];
          else if (paddr == hsbl_pkg::ADDR_RECEIVE_TICK_LIMIT) rx_tick_limit = pwdata[15:0];
        end else if (paddr == hsbl_pkg::ADDR_ACK_WAIT_LIMIT) begin
          check_field("ack_wait_limit read", ack_limit, prdata[7:0]);
          check_field("ack_wait_limit read upper", 8'd0, 8'(prdata[31:8] != 0));
        end else if (paddr == hsbl_pkg::ADDR_RECEIVE_TICK_LIMIT) begin
          if (prdata !== {16'd0, rx_tick_limit}) begin
            $display("%0t: receive_tick_limit read mismatch, expected %0h actual %0h",
                     $time, rx_tick_limit, prdata);
            errors++;
          end
        end
      end
      // Results are compared before this edge's request is predicted.
      if (m_tvalid && m_tready) begin
        if (link_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual tdata %0h tuser %0h",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = link_results_q.pop_front();
          check_field("data_out", want.data_out, m_tdata[0]);
          check_field("strobe_out", want.strobe_out, m_tdata[1]);
          check_field("rx_value", want.rx_value, m_tdata[9:2]);
          check_field("busy_res", want.busy_res, m_tdata[10]);
          check_field("status", want.status, m_tuser);
        end
      end
      if (s_tvalid && s_tready)
        link_results_q.push_back(step_link(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9]));
    end
    pending   <= link_results_q.size();
    link_idle <= (mode == hsbl_pkg::MODE_IDLE);
  end

endmodule

// File: bench/tb_top.sv
// Top of the handshake serial byte link bench: clock, reset, request and APB stimulus,
// random result stalls and the verdict. Depends on hsbl_pkg, handshake_serial_byte_link
// and hsbl_link_checker.

module tb_top;

  localparam int unsigned DATA_BITS   = 8;
  localparam int unsigned PHASE_ITEMS = 180;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned NO_STAGE    = 99;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [15:0]                  s_tdata;   // [7:0] tx_value, [8] data_in, [9] strobe_in
  logic                         s_tuser;   // [0] op
  logic                         m_tvalid;
  logic                         m_tready;
  logic [15:0]                  m_tdata;   // [0] data_out, [1] strobe_out, [9:2] rx_value,
                                           // [10] busy_res
  logic [2:0]                   m_tuser;   // [2:0] status
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [hsbl_pkg::ADDR_W-1:0]  paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  int                 errors;
  int                 pending;
  logic               link_idle;

  int unsigned        cycle_count = 0;
  int unsigned        items = 0;
  int unsigned        ack_cfg = hsbl_pkg::ACK_WAIT_LIMIT_RESET;
  int unsigned        rx_cfg = hsbl_pkg::RECEIVE_TICK_LIMIT_RESET;
  bit                 quiet = 1'b0;     // last phase: no idling on either side
  bit                 tx_calm = 1'b0;   // current script runs without sender gaps

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  handshake_serial_byte_link #(.DATA_BITS(DATA_BITS)) u_dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hsbl_link_checker #(.DATA_BITS(DATA_BITS)) u_check (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .errors, .pending, .link_idle
  );

  // Hard stop in case the link or the bench hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[handshake_serial_byte_link] ERROR");
      $finish;
    end
  end

  // Result side: m_tready in spells, some calm, some with random stall bursts.
  initial begin
    logic calm;
    m_tready <= 1'b0;
    forever begin
      calm = ($urandom_range(0, 3) == 0);
      repeat (64) begin
        @(posedge clk);
        if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Favor the byte extremes now and then.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one request (one poll tick) and hold it until accepted. Must start at a clock edge;
  // valid stays high on return so back-to-back requests need no extra step.
  task automatic send_tick(logic op, logic [7:0] tx, logic din, logic sin);
    if (!quiet && !tx_calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, sin, din, tx};
    items++;
    do @(posedge clk); while (!s_tready);
  endtask

  // Play the partner of a send: acknowledge the start, then each of the data bits and the
  // stop bit, with the acknowledge level toggling each time. Waits stay under the limit,
  // except on a chosen stage where the partner goes silent until the link gives up.
  task automatic drive_send(logic [7:0] value, logic fast, logic strobe_too);
    int unsigned lim;
    int unsigned give_up;
    int unsigned waits;
    logic        lvl;
    lim = (ack_cfg == 0) ? 1 : ack_cfg;
    give_up = NO_STAGE;
    if (!fast && $urandom_range(0, (lim <= 16) ? 5 : 29) == 0)
      give_up = $urandom_range(0, DATA_BITS + 1);
    lvl = 1'b1;
    // start tick: the acknowledge is not looked at yet, and a send beats an incoming strobe
    send_tick(hsbl_pkg::OP_SEND, value, strobe_too, strobe_too);
    for (int a = 0; a <= DATA_BITS + 1; a++) begin
      // strobe-high gap before every bit after the first; op and data are ignored here
      if (a >= 2) send_tick(coin(), 8'($urandom), coin(), coin());
      if (a == give_up) begin
        repeat (lim) send_tick(coin(), 8'($urandom), ~lvl, coin());
        return;
      end
      waits = fast ? 0 : $urandom_range(0, (lim > 5) ? 4 : lim - 1);
      repeat (waits) send_tick(coin(), 8'($urandom), ~lvl, coin());
      send_tick(coin(), 8'($urandom), lvl, coin());
      lvl = ~lvl;
    end
  endtask

  // Play the sender of a byte: raise strobe, then for each bit hold strobe high a while,
  // drop it with the bit on data and hold it low a while. Stop after the last sample or when
  // the receive limit runs out; sometimes stall mid-frame so the receiver times out.
  task automatic drive_receive(logic [7:0] value, logic fast);
    int unsigned lim;
    int unsigned cut;
    int unsigned ticks;
    int unsigned hold_hi;
    logic [8:0]  frame;
    lim   = (rx_cfg == 0) ? 1 : rx_cfg;
    frame = {fast || ($urandom_range(0, 7) != 0), value};
    cut   = (!fast && lim <= 300 && $urandom_range(0, 7) == 0) ?
            $urandom_range(0, DATA_BITS) : NO_STAGE;
    ticks = 0;
    send_tick(hsbl_pkg::OP_TICK, 8'($urandom), coin(), 1'b1);
    for (int b = 0; b <= DATA_BITS; b++) begin
      if (b == cut) begin
        while (ticks < lim) begin
          send_tick(coin(), 8'($urandom), coin(), 1'b1);
          ticks++;
        end
        return;
      end
      hold_hi = fast ? (b > 0) : $urandom_range((b > 0) ? 1 : 0, 3);
      repeat (hold_hi) begin
        send_tick(coin(), 8'($urandom), coin(), 1'b1);
        ticks++;
        if (ticks >= lim) return;
      end
      send_tick(coin(), 8'($urandom), frame[b], 1'b0);
      ticks++;
      if (b == DATA_BITS || ticks >= lim) return;
      repeat (fast ? 0 : $urandom_range(0, 2)) begin
        send_tick(coin(), 8'($urandom), coin(), 1'b0);
        ticks++;
        if (ticks >= lim) return;
      end
    end
  endtask

  // Walk the link back to idle: toggle strobe so a receive finishes, random data so a
  // send either completes or times out. Never offer a tick once the link is idle.
  task automatic flush_link();
    logic strobe_lvl;
    strobe_lvl = 1'b1;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (!link_idle) begin
      send_tick(hsbl_pkg::OP_TICK, 8'($urandom), coin(), strobe_lvl);
      strobe_lvl = ~strobe_lvl;
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold requests until the link is idle and every result has come back.
  task automatic settle();
    flush_link();
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [hsbl_pkg::ADDR_W-1:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random_script();
    int unsigned pick;
    pick    = $urandom_range(0, 19);
    tx_calm = ($urandom_range(0, 3) == 0);
    if (pick < 9) begin
      drive_send(pick_byte(), 1'b0, coin());
    end else if (pick < 17) begin
      drive_receive(pick_byte(), 1'b0);
    end else begin
      // noise: arbitrary ticks, then bring the link back to idle
      repeat ($urandom_range(1, 8)) send_tick(coin(), 8'($urandom), coin(), coin());
      flush_link();
    end
  endtask

  initial begin
    int unsigned ack_set [5];
    int unsigned rx_set [5];
    int unsigned goal;
    ack_set = '{100, 1, 255, 3, 100};
    rx_set  = '{100, 1, 65535, 20, 100};
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= hsbl_pkg::OP_TICK;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: plain ticks on an idle link, then a byte of all ones sent with the
    // partner's strobe high on the start tick and every acknowledge given at once.
    send_tick(hsbl_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
    send_tick(hsbl_pkg::OP_TICK, 8'hFF, 1'b1, 1'b0);
    drive_send(8'hFF, 1'b1, 1'b1);

    // Phase 0 runs on the reset limits; later phases rewrite both limits while idle.
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        settle();
        repeat (2) @(posedge clk);
        ack_cfg = ack_set[p];
        rx_cfg  = rx_set[p];
        apb_access(1'b1, hsbl_pkg::ADDR_ACK_WAIT_LIMIT, ack_cfg);
        apb_access(1'b1, hsbl_pkg::ADDR_RECEIVE_TICK_LIMIT, rx_cfg);
        apb_access(1'b0, hsbl_pkg::ADDR_ACK_WAIT_LIMIT, '0);
        apb_access(1'b0, hsbl_pkg::ADDR_RECEIVE_TICK_LIMIT, '0);
      end
      quiet = (p == 4);
      goal  = items + PHASE_ITEMS;
      while (items < goal) run_random_script();
    end

    settle();
    repeat (4) @(posedge clk);
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    if (errors == 0 && pending == 0) begin
      $display("[handshake_serial_byte_link] OK");
    end else begin
      $display("[handshake_serial_byte_link] ERROR");
    end
    $finish;
  end

endmodule
